>>> sv/dvru_pkg.sv
// Package for the distance-vector route update block.
// Holds the item and result structs, command codes and cost constants; no dependencies.
package dvru_pkg;

	localparam int N_NODES   = 16;
	localparam int NODE_W    = 4;
	localparam int ADDR_W    = 2 * NODE_W;
	localparam int COST_W    = 32;

	typedef logic signed [COST_W-1:0] cost_t;

	localparam cost_t UNREACH  = -32'sd1;
	localparam cost_t COST_MAX = 32'sh7fff_ffff;

	localparam logic [1:0] CMD_LINK     = 2'd0;
	localparam logic [1:0] CMD_ENTRY    = 2'd1;
	localparam logic [1:0] CMD_ANNOUNCE = 2'd2;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [NODE_W-1:0] from_node;
		logic [NODE_W-1:0] to_node;
		cost_t             path_cost;
		logic              last_entry;
	} item_t;

	typedef struct packed {
		logic [NODE_W-1:0] adv_target;
		cost_t             adv_cost;
		logic              adv_last;
	} adv_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		cost_t             data;
	} mem_wr_t;

endpackage

>>> sv/dvru_cost_mem.sv
// Cost table memory: one write port, one registered read port.
// Depends on dvru_pkg; entries never written read as unreachable through per-entry valid bits.
module dvru_cost_mem (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dvru_pkg::mem_wr_t       wr,
	input  logic [dvru_pkg::ADDR_W-1:0] raddr,
	output dvru_pkg::cost_t         rdata
);
	import dvru_pkg::*;

	localparam int DEPTH = N_NODES * N_NODES;

	cost_t            mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	cost_t            rdata_q;
	logic             rvld_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr.we) begin
				vld_q[wr.addr] <= 1'b1;
			end
			rvld_q <= vld_q[raddr];
		end
	end

	assign rdata = rvld_q ? rdata_q : UNREACH;

endmodule

>>> sv/distance_vector_route_update_top.sv
// Top level of the distance-vector route update block.
// Depends on dvru_pkg and dvru_cost_mem.
//
// Usage. Items arrive on item/item_valid/item_stall; a transfer happens when
// item_valid is high and item_stall is low. Results leave on adv/adv_valid/
// adv_stall the same way. own_node is written over cfg_data/cfg_valid/
// cfg_ready, which is always ready.
// Link-cost writes, non-final entries and ignored commands are handled without leaving idle.
// A final entry runs a recompute: it loads the own row from the table memory,
// relaxes it at one table read per cycle (set by the single memory read port),
// then writes back the row and sends changed entries, waiting whenever the
// receiver stalls a result. An announce sends each reachable link cost and
// waits on stalls the same way. item_stall is high for the whole of a
// recompute or announce.
// Reset clears all table valid bits so every cost reads as unreachable, sets
// every link cost unreachable and own_node to 0; no clearing pass is needed.
// A stalled result holds in the output register; the walk over the row
// waits on it, so no result is dropped.
module distance_vector_route_update_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dvru_pkg::item_t            item,
	input  logic                       item_valid,
	output logic                       item_stall,
	output dvru_pkg::adv_t             adv,
	output logic                       adv_valid,
	input  logic                       adv_stall,
	input  logic [dvru_pkg::NODE_W-1:0] cfg_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready
);
	import dvru_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOAD  = 3'd1;
	localparam logic [2:0] S_RELAX = 3'd2;
	localparam logic [2:0] S_EMIT  = 3'd3;
	localparam logic [2:0] S_ANN   = 3'd4;

	localparam int CNT_W = ADDR_W + 1;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              vld_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic [NODE_W-1:0] own_node_q;
	cost_t             row_q  [N_NODES];
	cost_t             ref_q  [N_NODES];
	cost_t             link_q [N_NODES];
	adv_t              adv_q;
	logic              adv_valid_q;

	mem_wr_t           wr;
	logic [ADDR_W-1:0] raddr;
	cost_t             rdata;

	logic              accept;
	cost_t             in_cost;
	logic [NODE_W-1:0] k_s1, i_s1, j_s1, e_idx;
	cost_t             load_link, load_val, load_new;
	cost_t             via, hop, cur;
	logic [COST_W:0]   raw_sum;
	cost_t             sum;
	logic              take;
	logic [N_NODES-1:0] chg, ann, mask, above;
	logic              slot_free, step_ok, cur_bit;

	dvru_cost_mem u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (wr),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign cfg_ready  = 1'b1;
	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;
	assign in_cost    = item.path_cost[COST_W-1] ? UNREACH : item.path_cost;

	// Pipeline views of the read issued in the previous cycle, and the walk index.
	assign k_s1 = idx_s1[NODE_W-1:0];
	assign i_s1 = idx_s1[ADDR_W-1:NODE_W];
	assign j_s1 = idx_s1[NODE_W-1:0];
	assign e_idx = cnt_q[NODE_W-1:0];

	always_comb begin
		raddr = {own_node_q, cnt_q[NODE_W-1:0]};
		if (state_q == S_RELAX) begin
			raddr = {cnt_q[NODE_W-1:0], cnt_q[ADDR_W-1:NODE_W]};
		end
	end

	// Link relaxation applied as the own row is loaded.
	assign load_link = link_q[k_s1];
	assign load_val  = rdata;
	assign load_new  = (load_link != UNREACH && (load_val == UNREACH || load_link < load_val))
		? load_link : load_val;

	// Path relaxation through node j toward target i. The own row lives in
	// row_q, so a hop out of the own node reads the working copy.
	assign via     = row_q[j_s1];
	assign cur     = row_q[i_s1];
	assign hop     = (j_s1 == own_node_q) ? cur : rdata;
	assign raw_sum = {1'b0, via} + {1'b0, hop};
	assign sum     = raw_sum[COST_W-1] ? COST_MAX : raw_sum[COST_W-1:0];
	assign take    = via != UNREACH && hop != UNREACH && (cur == UNREACH || sum < cur);

	always_comb begin
		for (int n = 0; n < N_NODES; n++) begin
			chg[n] = row_q[n] != ref_q[n];
			ann[n] = (NODE_W'(n) != own_node_q) && (link_q[n] != UNREACH);
		end
	end

	assign mask      = (state_q == S_EMIT) ? chg : ann;
	assign above     = mask >> e_idx;
	assign cur_bit   = above[0];
	assign slot_free = !adv_valid_q || !adv_stall;
	assign step_ok   = !cur_bit || slot_free;

	always_comb begin
		wr      = '0;
		wr.data = in_cost;
		if (accept && item.cmd == CMD_LINK) begin
			wr.we   = 1'b1;
			wr.addr = {own_node_q, item.to_node};
		end else if (accept && item.cmd == CMD_ENTRY) begin
			wr.we   = 1'b1;
			wr.addr = {item.from_node, item.to_node};
		end else if (state_q == S_EMIT) begin
			wr.we   = 1'b1;
			wr.addr = {own_node_q, e_idx};
			wr.data = row_q[e_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			own_node_q  <= '0;
			adv_valid_q <= 1'b0;
			for (int n = 0; n < N_NODES; n++) begin
				link_q[n] <= UNREACH;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				own_node_q <= cfg_data;
			end
			if (!adv_stall) begin
				adv_valid_q <= 1'b0;
			end
			vld_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						case (item.cmd)
							CMD_LINK: link_q[item.to_node] <= in_cost;
							CMD_ENTRY: begin
								if (item.last_entry) begin
									state_q <= S_LOAD;
								end
							end
							CMD_ANNOUNCE: state_q <= S_ANN;
							default: ;
						endcase
					end
				end
				S_LOAD: begin
					vld_s1 <= (cnt_q < CNT_W'(N_NODES));
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(N_NODES)) begin
						state_q <= S_RELAX;
						cnt_q   <= '0;
					end
				end
				S_RELAX: begin
					vld_s1 <= !cnt_q[ADDR_W];
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q[ADDR_W]) begin
						state_q <= S_EMIT;
						cnt_q   <= '0;
					end
				end
				S_EMIT, S_ANN: begin
					if (step_ok) begin
						cnt_q <= cnt_q + 1'b1;
						if (e_idx == NODE_W'(N_NODES - 1)) begin
							state_q <= S_IDLE;
							cnt_q   <= '0;
						end
					end
					if (cur_bit && slot_free) begin
						adv_valid_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= (state_q == S_RELAX) ? cnt_q[ADDR_W-1:0]
			: {{NODE_W{1'b0}}, cnt_q[NODE_W-1:0]};
		if (state_q == S_LOAD && vld_s1) begin
			row_q[k_s1] <= load_new;
			ref_q[k_s1] <= load_val;
		end
		if (state_q == S_RELAX && vld_s1 && take) begin
			row_q[i_s1] <= sum;
		end
		if ((state_q == S_EMIT || state_q == S_ANN) && cur_bit && slot_free) begin
			adv_q.adv_target <= e_idx;
			adv_q.adv_cost   <= (state_q == S_EMIT) ? row_q[e_idx] : link_q[e_idx];
			adv_q.adv_last   <= (above[N_NODES-1:1] == '0);
		end
	end

	assign adv       = adv_q;
	assign adv_valid = adv_valid_q;

	// A final received entry always starts a recompute.
	a_entry_starts_load: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.cmd == CMD_ENTRY && item.last_entry |=> state_q == S_LOAD)
		else $error("final entry did not start the row load");

	// The load only ever moves on to relaxation.
	a_load_to_relax: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD |=> state_q == S_LOAD || state_q == S_RELAX)
		else $error("row load left for a wrong state");

	// The walk counter is parked while the block waits for items.
	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && !accept |=> cnt_q == '0)
		else $error("walk counter not cleared in idle");

	// A new result is only loaded while walking a row.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_valid_q ##1 adv_valid_q |->
		$past(state_q) == S_EMIT || $past(state_q) == S_ANN)
		else $error("result appeared outside a row walk");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the distance-vector route update block.
// Depends on dvru_pkg and distance_vector_route_update_top; predicts each advertisement in-line.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import dvru_pkg::*;

	logic clk;
	logic arst_n;
	item_t item;
	logic item_valid;
	logic item_stall;
	adv_t adv;
	logic adv_valid;
	logic adv_stall;
	logic [NODE_W-1:0] cfg_data;
	logic cfg_valid;
	logic cfg_ready;

	distance_vector_route_update_top dut (
		.clk(clk), .arst_n(arst_n),
		.item(item), .item_valid(item_valid), .item_stall(item_stall),
		.adv(adv), .adv_valid(adv_valid), .adv_stall(adv_stall),
		.cfg_data(cfg_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
	);

	// Predictor state: a private copy of the table, link costs and own node.
	cost_t route_tab [N_NODES*N_NODES];
	cost_t link_tab [N_NODES];
	logic [NODE_W-1:0] my_node;

	item_t pending_items [$];
	adv_t expected_advs [$];
	int mismatches;
	int accepted_items;
	int cycles;
	logic hold_off;
	int hold_count;
	int send_gap;
	int recv_gap;

	function automatic cost_t clean_cost(cost_t c);
		return c[COST_W-1] ? UNREACH : c;
	endfunction

	function automatic cost_t sat_sum(cost_t a, cost_t b);
		logic [COST_W-1:0] s;
		s = a + b;
		return (s > COST_MAX) ? COST_MAX : cost_t'(s);
	endfunction

	function automatic void emit_adv(int tgt, cost_t c);
		adv_t a;
		a.adv_target = NODE_W'(tgt);
		a.adv_cost = c;
		a.adv_last = 1'b0;
		expected_advs.push_back(a);
	endfunction

	// Applies one accepted item and queues the advertisements it causes.
	function automatic void route_predict(item_t it);
		cost_t c;
		cost_t snap [N_NODES];
		cost_t via;
		cost_t hop;
		cost_t s;
		int base;
		int n;
		adv_t a;
		c = clean_cost(it.path_cost);
		n = 0;
		case (it.cmd)
			CMD_LINK: begin
				link_tab[it.to_node] = c;
				route_tab[my_node*N_NODES + it.to_node] = c;
			end
			CMD_ENTRY: begin
				route_tab[it.from_node*N_NODES + it.to_node] = c;
				if (it.last_entry) begin
					base = my_node * N_NODES;
					for (int i = 0; i < N_NODES; i++) snap[i] = route_tab[base+i];
					for (int i = 0; i < N_NODES; i++) begin
						if (link_tab[i] != UNREACH && (route_tab[base+i] == UNREACH ||
						    link_tab[i] < route_tab[base+i]))
							route_tab[base+i] = link_tab[i];
					end
					for (int i = 0; i < N_NODES; i++) begin
						for (int j = 0; j < N_NODES; j++) begin
							via = route_tab[base+j];
							hop = route_tab[j*N_NODES + i];
							if (via != UNREACH && hop != UNREACH) begin
								s = sat_sum(via, hop);
								if (route_tab[base+i] == UNREACH || s < route_tab[base+i])
									route_tab[base+i] = s;
							end
						end
					end
					for (int i = 0; i < N_NODES; i++) begin
						if (route_tab[base+i] != snap[i]) begin
							emit_adv(i, route_tab[base+i]);
							n++;
						end
					end
				end
			end
			CMD_ANNOUNCE: begin
				for (int i = 0; i < N_NODES; i++) begin
					if (i != my_node && link_tab[i] != UNREACH) begin
						emit_adv(i, link_tab[i]);
						n++;
					end
				end
			end
			default: ;
		endcase
		if (n > 0) begin
			a = expected_advs.pop_back();
			a.adv_last = 1'b1;
			expected_advs.push_back(a);
		end
	endfunction

	function automatic item_t make_item(logic [1:0] cmd, int frm, int to, cost_t c, int lst);
		item_t it;
		it.cmd = cmd;
		it.from_node = NODE_W'(frm);
		it.to_node = NODE_W'(to);
		it.path_cost = c;
		it.last_entry = (lst != 0);
		return it;
	endfunction

	function automatic cost_t rand_cost();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return UNREACH;
		if (r == 1) return cost_t'($urandom | 32'h8000_0000);
		if (r == 2) return cost_t'($urandom & 32'h7fff_ffff);
		if (r == 3) return COST_MAX - $urandom_range(0, 3);
		return cost_t'($urandom_range(0, 40));
	endfunction

	function automatic int pick_gap();
		return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Driver: offers the head of the pending queue; a transfer pops it and updates the predictor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			send_gap <= 0;
		end else begin
			if (item_valid && !item_stall) begin
				route_predict(item);
				accepted_items <= accepted_items + 1;
				void'(pending_items.pop_front());
			end
			if (item_valid && item_stall) begin
				// A stalled payload stays put.
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				item_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				item <= pending_items[0];
				item_valid <= 1'b1;
				send_gap <= pick_gap();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// The driver pops only after a transfer, so the head check above looks at the next item.
	// Monitor: compares each transferred result with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adv_stall <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (adv_valid && !adv_stall) begin
				if (expected_advs.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected advertisement target %0d cost %0d last %0b",
						         adv.adv_target, adv.adv_cost, adv.adv_last);
				end else begin
					if (adv !== expected_advs[0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("advertisement mismatch: exp %0d/%0d/%0b got %0d/%0d/%0b",
							         expected_advs[0].adv_target, expected_advs[0].adv_cost,
							         expected_advs[0].adv_last, adv.adv_target,
							         adv.adv_cost, adv.adv_last);
					end
					void'(expected_advs.pop_front());
				end
			end
			if (hold_off) begin
				adv_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				adv_stall <= 1'b1;
			end else begin
				adv_stall <= 1'b0;
				recv_gap <= pick_gap();
			end
		end
	end

	// Long receiver hold-off, timed in its own process while items keep coming.
	initial begin
		hold_off = 1'b0;
		hold_count = 0;
		wait (accepted_items > 40);
		@(posedge clk);
		hold_off <= 1'b1;
		while (hold_count < 3000) begin
			@(posedge clk);
			hold_count++;
		end
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1500000) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	task automatic wait_idle();
		while (pending_items.size() > 0 || expected_advs.size() > 0 || item_valid)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_own(logic [NODE_W-1:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		my_node = v;
	endtask

	// Random phase: mostly link setup and vectors that end in a recompute.
	task automatic random_phase(int count);
		int r;
		int len;
		for (int k = 0; k < count; ) begin
			r = $urandom_range(0, 9);
			if (r < 3) begin
				pending_items.push_back(make_item(CMD_LINK, $urandom_range(0, 15),
				                        $urandom_range(0, 15), rand_cost(), $urandom_range(0, 1)));
				k++;
			end else if (r < 8) begin
				len = $urandom_range(1, 5);
				for (int e = 0; e < len; e++)
					pending_items.push_back(make_item(CMD_ENTRY, $urandom_range(0, 15),
					                        $urandom_range(0, 15), rand_cost(), e == len - 1));
				k += len;
			end else if (r == 8) begin
				pending_items.push_back(make_item(CMD_ANNOUNCE, $urandom_range(0, 15),
				                        $urandom_range(0, 15), rand_cost(), $urandom_range(0, 1)));
				k++;
			end else begin
				pending_items.push_back(make_item(2'd3, $urandom_range(0, 15),
				                        $urandom_range(0, 15), rand_cost(), $urandom_range(0, 1)));
				k++;
			end
		end
	endtask

	initial begin
		for (int i = 0; i < N_NODES*N_NODES; i++) route_tab[i] = UNREACH;
		for (int i = 0; i < N_NODES; i++) link_tab[i] = UNREACH;
		my_node = '0;
		mismatches = 0;
		accepted_items = 0;
		cycles = 0;
		cfg_data = '0;
		cfg_valid = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: own node 0, announce with nothing reachable, links and extremes.
		write_own(4'd0);
		pending_items.push_back(make_item(CMD_ANNOUNCE, 0, 0, 0, 0));
		pending_items.push_back(make_item(CMD_ENTRY, 0, 0, 0, 1));
		pending_items.push_back(make_item(CMD_LINK, 0, 1, 5, 0));
		pending_items.push_back(make_item(CMD_LINK, 0, 2, COST_MAX, 0));
		pending_items.push_back(make_item(CMD_LINK, 0, 15, -32'sd7, 1));
		pending_items.push_back(make_item(CMD_LINK, 0, 0, 0, 0));
		pending_items.push_back(make_item(CMD_ENTRY, 2, 3, COST_MAX, 0));
		pending_items.push_back(make_item(CMD_ENTRY, 1, 4, 3, 0));
		pending_items.push_back(make_item(CMD_ENTRY, 15, 15, 32'sh8000_0000, 0));
		pending_items.push_back(make_item(CMD_ENTRY, 1, 3, 1, 1));
		pending_items.push_back(make_item(CMD_ANNOUNCE, 15, 15, UNREACH, 1));
		pending_items.push_back(make_item(2'd3, 15, 15, UNREACH, 1));
		pending_items.push_back(make_item(CMD_ENTRY, 0, 0, 0, 1));
		wait_idle();

		// Own node 15 with a link cost to every node, so the announce sends every node but the own one.
		write_own(4'd15);
		for (int i = 0; i < N_NODES; i++)
			pending_items.push_back(make_item(CMD_LINK, 0, i, i + 1, 0));
		pending_items.push_back(make_item(CMD_ENTRY, 3, 7, 0, 1));
		pending_items.push_back(make_item(CMD_ANNOUNCE, 0, 0, 0, 0));
		wait_idle();

		write_own(4'd7);
		random_phase(60);
		wait_idle();
		write_own(4'($urandom_range(0, 15)));
		random_phase(50);
		wait_idle();
		write_own(4'd0);
		random_phase(20);
		wait_idle();

		if (mismatches == 0 && expected_advs.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end
endmodule
